>>> rtl/core/grdp_pkg.sv
// Widths, register indexes, config, items and div/mul types for the gyro PID.
`default_nettype none
package grdp_pkg;
	localparam int FactorWidth = 16;
	localparam int StickSpeedMult = 5;
	localparam int AddrWidth = 5;
	localparam int QuoWidth = FactorWidth + 2;

	typedef enum logic [2:0] {
		REG_CENTER   = 3'd0,
		REG_DEADBAND = 3'd1,
		REG_RANGE    = 3'd2,
		REG_CURVE    = 3'd3,
		REG_KP       = 3'd4,
		REG_KI       = 3'd5,
		REG_KD       = 3'd6,
		REG_ILIMIT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] stick_center;
		logic [15:0] deadband;
		logic [15:0] stick_range;
		logic [1:0]  gain_curve;
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kd;
		logic [22:0] integral_limit;
	} cfg_t;

	typedef struct packed {
		logic        update_enable;
		logic [15:0] rate;
		logic [15:0] stick_position;
		logic [15:0] loop_gain;
	} in_item_t;

	typedef struct packed {
		logic [47:0] correction_delta;
	} out_item_t;

	// Divider request/response between sequencer and serial divider.
	typedef struct packed {
		logic        start;
		logic [39:0] num;
		logic [17:0] den;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [QuoWidth-1:0] quo;
	} div_rsp_t;

	// Multiplier request/response: signed a times unsigned b.
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [16:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [80:0] prod;
	} mul_rsp_t;
endpackage
`default_nettype wire

>>> rtl/core/grdp_stream_if.sv
// Valid/ready stream interface carrying one payload.
`default_nettype none
interface grdp_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/grdp_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturates to QuoWidth bits.
`default_nettype none
module grdp_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  grdp_pkg::div_req_t  req,
	output grdp_pkg::div_rsp_t  rsp
);
	localparam int NumW = 40;
	logic [NumW-1:0] num_q;
	logic [17:0]     den_q;
	logic [18:0]     rem_q;
	logic [NumW-1:0] quo_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [18:0]     trial;
	logic [18:0]     diff;

	assign trial = {rem_q[17:0], num_q[NumW-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			if (!diff[18]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		if (|quo_q[NumW-1:grdp_pkg::QuoWidth])
			rsp.quo = '1;
		else
			rsp.quo = quo_q[grdp_pkg::QuoWidth-1:0];
	end

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) req.start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q != 6'd0)
		else $error("divider count underflow");
endmodule
`default_nettype wire

>>> rtl/core/grdp_mul.sv
// Shift-add multiplier, signed 64-bit times unsigned 17-bit, one bit of b per cycle.
`default_nettype none
module grdp_mul (
	input  wire                 clk,
	input  wire                 arst_n,
	input  grdp_pkg::mul_req_t  req,
	output grdp_pkg::mul_rsp_t  rsp
);
	logic signed [80:0] acc_q;
	logic signed [80:0] a_q;
	logic [16:0]        b_q;
	logic [4:0]         cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q <= 81'(signed'(req.a));
			b_q <= req.b;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("multiplier done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) req.start |=> busy_q)
		else $error("multiplier did not start");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q != 5'd0)
		else $error("multiplier count underflow");
endmodule
`default_nettype wire

>>> rtl/core/gyro_rate_damping_pid.sv
// Gyro damping PID for one axis: config port, sequencer and serial arithmetic units.
//
// Use: write registers over the APB port while idle, then send one item per
// control period on in_ch; one result leaves on out_ch per accepted item.
// A disabled item (update_enable low) returns zero through ST_OUT and the
// output register and leaves state untouched. An enabled item runs a
// sequence on one shared bit-serial divider (two divisions), a bit-serial
// divide-by-three for smoothing and one shift-add multiplier (six products);
// out_ch.valid rises once ST_OUT follows the gain product. Most of each
// item's time goes to the divider's quotient-bit loop and the multiplier's
// bit loop.
// One item is in flight at a time: in_ch.ready is high only while the
// sequencer is idle and no result waits.
// The result sits in an output register until out_ch takes it; while the
// receiver stalls the block holds it and takes no new item.
// Reset (arst_n low) returns config and control registers to reset values,
// clears the rate, stick, error and integrator history, drops out_ch.valid.
`default_nettype none
module gyro_rate_damping_pid (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire [4:0]    paddr,
	input  wire [31:0]   pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	grdp_stream_if.sink   in_ch,
	grdp_stream_if.source out_ch
);
	typedef enum logic [15:0] {
		ST_IDLE  = 16'h0001,
		ST_PF    = 16'h0002,
		ST_PFW   = 16'h0004,
		ST_SF    = 16'h0008,
		ST_SFW   = 16'h0010,
		ST_M1    = 16'h0020,
		ST_M1W   = 16'h0040,
		ST_M2    = 16'h0080,
		ST_M2W   = 16'h0100,
		ST_DIV3  = 16'h0200,
		ST_PID   = 16'h0400,
		ST_PIDW  = 16'h0800,
		ST_GAIN  = 16'h1000,
		ST_GAINW = 16'h2000,
		ST_OUT   = 16'h4000
	} state_t;

	grdp_pkg::cfg_t cfg_q;
	state_t         state_q;
	logic           out_valid_q;
	logic [47:0]    out_data_q;

	logic signed [15:0] prev_rate_q;
	logic [15:0]        prev_stick_q;
	logic signed [23:0] prev_err_q;
	logic signed [23:0] integ_q;

	logic               en_q;
	logic signed [15:0] rate_q;
	logic [15:0]        stick_q;
	logic [15:0]        gain_q;
	logic signed [63:0] work_q;
	logic [16:0]        pf_q;
	logic [16:0]        sf_q;
	logic signed [23:0] smooth_q;
	logic signed [23:0] derr_q;
	logic [1:0]         pid_idx_q;
	logic signed [63:0] pid_acc_q;
	logic [4:0]         d3_cnt_q;
	logic [26:0]        d3_rem_q;
	logic [1:0]         d3_r_q;
	logic               d3_neg_q;

	grdp_pkg::div_req_t div_req;
	grdp_pkg::div_rsp_t div_rsp;
	grdp_pkg::mul_req_t mul_req;
	grdp_pkg::mul_rsp_t mul_rsp;

	grdp_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	grdp_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));

	// config port
	logic       wr_en;
	logic [2:0] ridx;
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_center <= 16'd32768;
			cfg_q.deadband <= 16'd0;
			cfg_q.stick_range <= 16'd32767;
			cfg_q.gain_curve <= 2'd0;
			cfg_q.kp <= 16'd0;
			cfg_q.ki <= 16'd0;
			cfg_q.kd <= 16'd0;
			cfg_q.integral_limit <= 23'h7FFFFF;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			unique case (grdp_pkg::reg_idx_t'(ridx))
				grdp_pkg::REG_CENTER:   cfg_q.stick_center <= pwdata[15:0];
				grdp_pkg::REG_DEADBAND: cfg_q.deadband <= pwdata[15:0];
				grdp_pkg::REG_RANGE:    cfg_q.stick_range <= pwdata[15:0];
				grdp_pkg::REG_CURVE:    cfg_q.gain_curve <= pwdata[1:0];
				grdp_pkg::REG_KP:       cfg_q.kp <= pwdata[15:0];
				grdp_pkg::REG_KI:       cfg_q.ki <= pwdata[15:0];
				grdp_pkg::REG_KD:       cfg_q.kd <= pwdata[15:0];
				grdp_pkg::REG_ILIMIT:   cfg_q.integral_limit <= pwdata[22:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (grdp_pkg::reg_idx_t'(ridx))
			grdp_pkg::REG_CENTER:   prdata = {16'd0, cfg_q.stick_center};
			grdp_pkg::REG_DEADBAND: prdata = {16'd0, cfg_q.deadband};
			grdp_pkg::REG_RANGE:    prdata = {16'd0, cfg_q.stick_range};
			grdp_pkg::REG_CURVE:    prdata = {30'd0, cfg_q.gain_curve};
			grdp_pkg::REG_KP:       prdata = {16'd0, cfg_q.kp};
			grdp_pkg::REG_KI:       prdata = {16'd0, cfg_q.ki};
			grdp_pkg::REG_KD:       prdata = {16'd0, cfg_q.kd};
			grdp_pkg::REG_ILIMIT:   prdata = {9'd0, cfg_q.integral_limit};
			default: prdata = '0;
		endcase
	end

	// combinational helpers
	logic [16:0] range_eff;
	logic [15:0] off;
	logic [16:0] dmag;
	logic signed [16:0] dstick;
	logic [17:0] pf_den;
	logic [39:0] pf_num;
	logic [16:0] one_c;

	assign one_c = 17'(1) << grdp_pkg::FactorWidth;
	assign range_eff = (cfg_q.stick_range == 16'd0) ? 17'd1 : {1'b0, cfg_q.stick_range};
	assign off = (stick_q >= cfg_q.stick_center) ? stick_q - cfg_q.stick_center
		: cfg_q.stick_center - stick_q;
	assign dstick = signed'({1'b0, stick_q}) - signed'({1'b0, prev_stick_q});
	assign dmag = dstick[16] ? 17'(-dstick) : 17'(dstick);

	always_comb begin
		pf_num = 40'(off) << grdp_pkg::FactorWidth;
		pf_den = {1'b0, range_eff};
		case (cfg_q.gain_curve)
			2'd1: pf_den = {range_eff, 1'b0};
			2'd2: pf_num = 40'(off) << (grdp_pkg::FactorWidth + 1);
			default: ;
		endcase
	end

	function automatic logic [16:0] fac(input logic [grdp_pkg::QuoWidth-1:0] q);
		logic [16:0] o;
		o = 17'(1) << grdp_pkg::FactorWidth;
		if (q >= grdp_pkg::QuoWidth'(o))
			fac = '0;
		else
			fac = o - 17'(q);
	endfunction

	// |prod| >> FactorWidth with sign restored; prod is err*factor
	logic signed [63:0] scaled;
	logic [80:0]        pmag;
	always_comb begin
		pmag = mul_rsp.prod[80] ? 81'(-mul_rsp.prod) : mul_rsp.prod;
		scaled = signed'(64'(pmag >> grdp_pkg::FactorWidth));
		if (mul_rsp.prod[80])
			scaled = -scaled;
	end

	// smoothing: (e + 2*prev) / 3 by restoring division, one bit per step
	logic signed [26:0] sm_sum;
	logic [26:0]        sm_mag;
	assign sm_sum = 27'(work_q) + 27'(prev_err_q) + 27'(prev_err_q);
	assign sm_mag = sm_sum[26] ? 27'(-sm_sum) : sm_sum;

	logic [2:0]  d3_trial;
	logic        d3_qbit;
	logic [26:0] d3_quo;
	assign d3_trial = {d3_r_q, d3_rem_q[26]};
	assign d3_qbit = d3_trial >= 3'd3;
	assign d3_quo = d3_rem_q;

	logic signed [26:0] sm_val;
	logic signed [23:0] sm_clamped;
	logic signed [24:0] integ_sum;
	logic signed [24:0] lim_pos;
	logic signed [23:0] integ_next;
	always_comb begin
		sm_val = d3_neg_q ? 27'(-d3_quo) : 27'(d3_quo);
		if (sm_val > 27'sh7FFFFF)
			sm_clamped = 24'sh7FFFFF;
		else if (sm_val < -27'sh800000)
			sm_clamped = -24'sh800000;
		else
			sm_clamped = 24'(sm_val);
		integ_sum = 25'(integ_q) + 25'(sm_clamped);
		lim_pos = signed'({2'b00, cfg_q.integral_limit});
		if (integ_sum > lim_pos)
			integ_next = 24'(lim_pos);
		else if (integ_sum < -lim_pos)
			integ_next = 24'(-lim_pos);
		else
			integ_next = 24'(integ_sum);
	end

	// result: pid*gain / 32768 toward zero, saturate to 48 bits
	logic signed [80:0] res_full;
	logic signed [80:0] res_adj;
	logic [47:0]        res_sat;
	always_comb begin
		res_adj = mul_rsp.prod;
		if (mul_rsp.prod[80])
			res_adj = mul_rsp.prod + 81'sd32767;
		res_full = res_adj >>> 15;
		if (res_full > 81'sh7FFFFFFFFFFF)
			res_sat = 48'h7FFFFFFFFFFF;
		else if (res_full < -81'sh800000000000)
			res_sat = 48'h800000000000;
		else
			res_sat = res_full[47:0];
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data.correction_delta = out_data_q;

	always_comb begin
		div_req = '0;
		mul_req = '0;
		unique case (state_q)
			ST_PF: begin
				div_req.start = 1'b1;
				div_req.num = pf_num;
				div_req.den = pf_den;
			end
			ST_SF: begin
				div_req.start = 1'b1;
				div_req.num = 40'(20'(grdp_pkg::StickSpeedMult) * 20'(dmag))
					<< grdp_pkg::FactorWidth;
				div_req.den = {1'b0, range_eff};
			end
			ST_M1: begin
				mul_req.start = 1'b1;
				mul_req.a = work_q;
				mul_req.b = pf_q;
			end
			ST_M2: begin
				mul_req.start = 1'b1;
				mul_req.a = work_q;
				mul_req.b = sf_q;
			end
			ST_PID: begin
				mul_req.start = 1'b1;
				case (pid_idx_q)
					2'd0: begin
						mul_req.a = 64'(smooth_q);
						mul_req.b = {1'b0, cfg_q.kp};
					end
					2'd1: begin
						mul_req.a = 64'(integ_q);
						mul_req.b = {1'b0, cfg_q.ki};
					end
					default: begin
						mul_req.a = 64'(derr_q);
						mul_req.b = {1'b0, cfg_q.kd};
					end
				endcase
			end
			ST_GAIN: begin
				mul_req.start = 1'b1;
				mul_req.a = pid_acc_q;
				mul_req.b = {1'b0, gain_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			prev_rate_q <= '0;
			prev_stick_q <= '0;
			prev_err_q <= '0;
			integ_q <= '0;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_ch.valid && in_ch.ready)
					state_q <= in_ch.data.update_enable ? ST_PF : ST_OUT;
				ST_PF: begin
					state_q <= ST_PFW;
					prev_rate_q <= rate_q;
				end
				ST_PFW: if (div_rsp.done) state_q <= ST_SF;
				ST_SF: state_q <= ST_SFW;
				ST_SFW: if (div_rsp.done) begin
					state_q <= ST_M1;
					prev_stick_q <= stick_q;
				end
				ST_M1: state_q <= ST_M1W;
				ST_M1W: if (mul_rsp.done) state_q <= ST_M2;
				ST_M2: state_q <= ST_M2W;
				ST_M2W: if (mul_rsp.done) state_q <= ST_DIV3;
				ST_DIV3: if (d3_cnt_q == 5'd28) begin
					state_q <= ST_PID;
					prev_err_q <= sm_clamped;
					integ_q <= integ_next;
				end
				ST_PID: state_q <= ST_PIDW;
				ST_PIDW: if (mul_rsp.done)
					state_q <= (pid_idx_q == 2'd2) ? ST_GAIN : ST_PID;
				ST_GAIN: state_q <= ST_GAINW;
				ST_GAINW: if (mul_rsp.done) state_q <= ST_OUT;
				ST_OUT: begin
					state_q <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				en_q <= in_ch.data.update_enable;
				rate_q <= in_ch.data.rate;
				stick_q <= in_ch.data.stick_position;
				gain_q <= in_ch.data.loop_gain;
				pid_idx_q <= '0;
				pid_acc_q <= '0;
				d3_cnt_q <= '0;
				if (in_ch.valid && in_ch.ready)
					out_data_q <= '0;
			end
			ST_PF: work_q <= 64'(prev_rate_q) - 64'(rate_q);
			ST_PFW: if (div_rsp.done)
				pf_q <= (off < cfg_q.deadband) ? one_c : fac(div_rsp.quo);
			ST_SFW: if (div_rsp.done) sf_q <= fac(div_rsp.quo);
			ST_M1W: if (mul_rsp.done) work_q <= scaled;
			ST_M2W: if (mul_rsp.done) work_q <= scaled;
			ST_DIV3: begin
				d3_cnt_q <= d3_cnt_q + 5'd1;
				if (d3_cnt_q == 5'd0) begin
					d3_rem_q <= sm_mag;
					d3_r_q <= '0;
					d3_neg_q <= sm_sum[26];
				end else if (d3_cnt_q != 5'd28) begin
					d3_r_q <= d3_qbit ? 2'(d3_trial - 3'd3) : d3_trial[1:0];
					d3_rem_q <= {d3_rem_q[25:0], d3_qbit};
				end
				if (d3_cnt_q == 5'd28) begin
					smooth_q <= sm_clamped;
					derr_q <= sm_clamped - prev_err_q;
				end
			end
			ST_PIDW: if (mul_rsp.done) begin
				pid_acc_q <= pid_acc_q + 64'(mul_rsp.prod);
				pid_idx_q <= pid_idx_q + 2'd1;
			end
			ST_GAINW: if (mul_rsp.done) out_data_q <= res_sat;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> out_valid_q)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !en_q) |=> out_data_q == 48'd0)
		else $error("disabled item gave nonzero result");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_data_q))
		else $error("result lost under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ch.ready)
		else $error("input taken while a result waits");
endmodule
`default_nettype wire
